// ===== design/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg: shared types and constants of the quaternion to rotation matrix unit
// Holds the word format, the internal datapath widths and the request,
// result and pipeline lane types.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // Word format: signed Q1.14.
  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 14;

  // Product, sum, norm, remainder and quotient widths.
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int SUM_W  = 2 * WORD_BITS + 2;
  localparam int NORM_W = 2 * WORD_BITS + 1;
  localparam int REM_W  = NORM_W + 1;
  localparam int QUO_W  = FRAC_BITS + 2;

  // Shift-and-subtract steps after the initial compare.
  localparam int DIV_STEPS = FRAC_BITS + 1;

  // Number of matrix entries.
  localparam int NUM_ENT = 9;

  // Saturation limit: 1.0, or the largest positive word if 1.0 does not fit.
  localparam longint ONE_VAL = longint'(1) << FRAC_BITS;
  localparam longint TOP_VAL = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint LIM_VAL = (ONE_VAL < TOP_VAL) ? ONE_VAL : TOP_VAL;
  localparam logic [QUO_W-1:0] SAT_LIM = QUO_W'(LIM_VAL);

  // Total latency from request to result strobe.
  localparam int LATENCY = 3 + DIV_STEPS + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t quat_w;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
  } quat_req_t;

  typedef struct packed {
    word_t m00;
    word_t m01;
    word_t m02;
    word_t m10;
    word_t m11;
    word_t m12;
    word_t m20;
    word_t m21;
    word_t m22;
    logic  zero_norm;
  } mat_res_t;

  // One division lane: sign of the entry, partial remainder, quotient so far.
  typedef struct packed {
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef div_lane_t [NUM_ENT-1:0] lane_vec_t;

  // Control that travels along the divider stages.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [NORM_W-1:0] norm;
  } pipe_ctl_t;

endpackage

// ===== design/qrm_front.sv =====
// ----------------------------------------------------------------------------
// qrm_front: products, sums and the first quotient bit
// Three register stages: the ten products, the norm and nine signed
// numerators, then sign/magnitude split with the leading quotient bit.
// ----------------------------------------------------------------------------
module qrm_front
  import qrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  quat_req_t req,
  output pipe_ctl_t ctl,
  output lane_vec_t lanes
);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Stage 1 registers.
  logic  v1_r;
  prod_t ww_r, xx_r, yy_r, zz_r, xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;

  // Stage 2 registers.
  logic              v2_r;
  logic [NORM_W-1:0] norm2_r;
  sum_t              num_r [NUM_ENT];
  sum_t              num_nxt [NUM_ENT];
  logic [NORM_W-1:0] norm_nxt;

  // Stage 3 registers.
  pipe_ctl_t ctl_r;
  lane_vec_t lanes_r;
  lane_vec_t lanes_nxt;

  // Stage 1: all products of the four components.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    ww_r <= req.quat_w * req.quat_w;
    xx_r <= req.quat_x * req.quat_x;
    yy_r <= req.quat_y * req.quat_y;
    zz_r <= req.quat_z * req.quat_z;
    xy_r <= req.quat_x * req.quat_y;
    zw_r <= req.quat_z * req.quat_w;
    xz_r <= req.quat_x * req.quat_z;
    yw_r <= req.quat_y * req.quat_w;
    yz_r <= req.quat_y * req.quat_z;
    xw_r <= req.quat_x * req.quat_w;
  end

  // Stage 2: squared norm and the nine numerators, off-diagonal ones doubled.
  always_comb begin
    sum_t e_ww, e_xx, e_yy, e_zz, e_xy, e_zw, e_xz, e_yw, e_yz, e_xw;
    e_ww = SUM_W'(ww_r);
    e_xx = SUM_W'(xx_r);
    e_yy = SUM_W'(yy_r);
    e_zz = SUM_W'(zz_r);
    e_xy = SUM_W'(xy_r);
    e_zw = SUM_W'(zw_r);
    e_xz = SUM_W'(xz_r);
    e_yw = SUM_W'(yw_r);
    e_yz = SUM_W'(yz_r);
    e_xw = SUM_W'(xw_r);
    // Squares are never negative, so the low product bits are the magnitude.
    norm_nxt = NORM_W'(ww_r[PROD_W-1:0]) + NORM_W'(xx_r[PROD_W-1:0])
             + NORM_W'(yy_r[PROD_W-1:0]) + NORM_W'(zz_r[PROD_W-1:0]);
    num_nxt[0] = e_ww + e_xx - e_yy - e_zz;
    num_nxt[1] = (e_xy - e_zw) <<< 1;
    num_nxt[2] = (e_xz + e_yw) <<< 1;
    num_nxt[3] = (e_xy + e_zw) <<< 1;
    num_nxt[4] = e_ww - e_xx + e_yy - e_zz;
    num_nxt[5] = (e_yz - e_xw) <<< 1;
    num_nxt[6] = (e_xz - e_yw) <<< 1;
    num_nxt[7] = (e_yz + e_xw) <<< 1;
    num_nxt[8] = e_ww - e_xx - e_yy + e_zz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    norm2_r <= norm_nxt;
    num_r   <= num_nxt;
  end

  // Stage 3: magnitude of each numerator and the leading quotient bit.
  // The magnitude never exceeds the norm, so that bit is set only on equality.
  always_comb begin
    sum_t              abs_v;
    logic [NORM_W-1:0] mag;
    for (int i = 0; i < NUM_ENT; i++) begin
      abs_v = num_r[i][SUM_W-1] ? -num_r[i] : num_r[i];
      mag   = abs_v[NORM_W-1:0];
      lanes_nxt[i].neg = num_r[i][SUM_W-1];
      if (mag == norm2_r) begin
        lanes_nxt[i].rem = '0;
        lanes_nxt[i].quo = QUO_W'(1);
      end else begin
        lanes_nxt[i].rem = REM_W'(mag);
        lanes_nxt[i].quo = '0;
      end
    end
  end

  // Only the valid bit is reset; the data fields follow every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= v2_r;
    end
    ctl_r.zero <= (norm2_r == '0);
    ctl_r.norm <= norm2_r;
    lanes_r    <= lanes_nxt;
  end

  assign ctl   = ctl_r;
  assign lanes = lanes_r;

endmodule

// ===== design/qrm_div_step.sv =====
// ----------------------------------------------------------------------------
// qrm_div_step: one restoring division step for all nine lanes
// Shifts each remainder left, subtracts the norm where it fits and appends
// one quotient bit, then registers the lanes and the control.
// ----------------------------------------------------------------------------
module qrm_div_step
  import qrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl_i,
  input  lane_vec_t lanes_i,
  output pipe_ctl_t ctl_o,
  output lane_vec_t lanes_o
);

  pipe_ctl_t ctl_r;
  lane_vec_t lanes_r;
  lane_vec_t lanes_nxt;

  // Compare and subtract on the doubled remainder.
  always_comb begin
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] div_v;
    div_v = REM_W'(ctl_i.norm);
    for (int i = 0; i < NUM_ENT; i++) begin
      rem2 = {lanes_i[i].rem[REM_W-2:0], 1'b0};
      lanes_nxt[i].neg = lanes_i[i].neg;
      if (rem2 >= div_v) begin
        lanes_nxt[i].rem = rem2 - div_v;
        lanes_nxt[i].quo = {lanes_i[i].quo[QUO_W-2:0], 1'b1};
      end else begin
        lanes_nxt[i].rem = rem2;
        lanes_nxt[i].quo = {lanes_i[i].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  // Only the valid bit is reset; the data fields follow every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.zero <= ctl_i.zero;
    ctl_r.norm <= ctl_i.norm;
    lanes_r    <= lanes_nxt;
  end

  assign ctl_o   = ctl_r;
  assign lanes_o = lanes_r;

endmodule

// ===== design/qrm_round.sv =====
// ----------------------------------------------------------------------------
// qrm_round: rounding, saturation and sign of the nine entries
// Rounds each quotient half away from zero, holds it at the limit, applies
// the sign and forces zero entries for a zero quaternion.
// ----------------------------------------------------------------------------
module qrm_round
  import qrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl_i,
  input  lane_vec_t lanes_i,
  output logic      res_valid,
  output mat_res_t  res
);

  logic     valid_r;
  mat_res_t res_r;
  mat_res_t res_nxt;
  word_t    ent [NUM_ENT];

  // Round, clamp and sign each entry.
  always_comb begin
    logic [QUO_W:0]   sum1;
    logic [QUO_W-1:0] rnd;
    logic [QUO_W-1:0] sat;
    word_t            mag_w;
    for (int i = 0; i < NUM_ENT; i++) begin
      sum1  = {1'b0, lanes_i[i].quo} + (QUO_W + 1)'(1);
      rnd   = sum1[QUO_W:1];
      sat   = (rnd > SAT_LIM) ? SAT_LIM : rnd;
      mag_w = WORD_BITS'(sat);
      if (ctl_i.zero) begin
        ent[i] = '0;
      end else if (lanes_i[i].neg) begin
        ent[i] = -mag_w;
      end else begin
        ent[i] = mag_w;
      end
    end
    res_nxt.m00       = ent[0];
    res_nxt.m01       = ent[1];
    res_nxt.m02       = ent[2];
    res_nxt.m10       = ent[3];
    res_nxt.m11       = ent[4];
    res_nxt.m12       = ent[5];
    res_nxt.m20       = ent[6];
    res_nxt.m21       = ent[7];
    res_nxt.m22       = ent[8];
    res_nxt.zero_norm = ctl_i.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== design/quaternion_to_rotation_matrix_unit.sv =====
// Pipeline: three front stages, FRAC_BITS + 1 division stages and one
// rounding stage lie between an accepted request and its result strobe.
// Throughput: one request per cycle; busy is always low.
// The division pipeline, one quotient bit per stage, sets the latency.
// Synchronous active-low reset clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit: quaternion to 3x3 rotation matrix
// Converts a Q1.14 quaternion of any length into the nine normalized,
// saturated Q1.14 matrix entries, with a flag for the zero quaternion.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit
  import qrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  quat_req_t in_req,
  output logic      out_valid,
  output mat_res_t  out_res
);

  pipe_ctl_t ctl_chain   [DIV_STEPS+1];
  lane_vec_t lanes_chain [DIV_STEPS+1];

  // The pipeline never stalls, so a request is taken every cycle.
  assign busy = 1'b0;

  // Products, numerators and the leading quotient bit.
  qrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (start),
    .req       (in_req),
    .ctl       (ctl_chain[0]),
    .lanes     (lanes_chain[0])
  );

  // One division stage per remaining quotient bit.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    qrm_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl_chain[s]),
      .lanes_i (lanes_chain[s]),
      .ctl_o   (ctl_chain[s+1]),
      .lanes_o (lanes_chain[s+1])
    );
  end

  // Rounding and output register.
  qrm_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_chain[DIV_STEPS]),
    .lanes_i   (lanes_chain[DIV_STEPS]),
    .res_valid (out_valid),
    .res       (out_res)
  );

`ifndef ASSERT_OFF
  // A zero quaternion gives an all-zero matrix.
  a_zero_entries: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.zero_norm |->
      out_res.m00 == '0 && out_res.m01 == '0 && out_res.m02 == '0 &&
      out_res.m10 == '0 && out_res.m11 == '0 && out_res.m12 == '0 &&
      out_res.m20 == '0 && out_res.m21 == '0 && out_res.m22 == '0)
    else $error("zero quaternion produced a nonzero entry");

  // Diagonal entries stay within the saturation limit.
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_res.m00 <= word_t'(LIM_VAL) && out_res.m00 >= -word_t'(LIM_VAL) &&
      out_res.m11 <= word_t'(LIM_VAL) && out_res.m11 >= -word_t'(LIM_VAL) &&
      out_res.m22 <= word_t'(LIM_VAL) && out_res.m22 >= -word_t'(LIM_VAL))
    else $error("diagonal entry beyond saturation limit");

  // The divisor handed to the last stage matches its zero flag.
  a_norm_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_chain[DIV_STEPS].valid |->
      (ctl_chain[DIV_STEPS].norm == '0) == ctl_chain[DIV_STEPS].zero)
    else $error("zero flag disagrees with the norm");
`endif

endmodule

// ===== bench/quaternion_to_rotation_matrix_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix checker
// Watches the request and result channels, computes the expected matrix for
// every accepted request and compares each result strobe field by field.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit_checker
  import qrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  quat_req_t in_req,
  input  logic      out_valid,
  input  mat_res_t  out_res,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  mat_res_t expected_mats[$];

  // Rounded, saturated quotient of a signed exact value over the norm.
  // The value is shifted left by shift bits first (FRAC_BITS + 1 for diagonal terms).
  function automatic word_t norm_entry(logic signed [SUM_W:0] num, logic [NORM_W-1:0] nrm,
                                       int shift);
    logic [SUM_W:0] mag;
    logic [127:0]   q;
    longint         r;
    mag = num[SUM_W] ? -num : num;
    q = ({64'd0, 64'(mag)} << shift) / {64'd0, 64'(nrm)};
    r = longint'((q + 1) >> 1);
    if (r > LIM_VAL) r = LIM_VAL;
    return num[SUM_W] ? word_t'(-r) : word_t'(r);
  endfunction

  // Expected matrix for one quaternion.
  function automatic mat_res_t rotation_of(quat_req_t q);
    mat_res_t m;
    logic signed [SUM_W:0] w, x, y, z, ww, xx, yy, zz;
    logic [NORM_W-1:0] nrm;
    int kd, ko;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    nrm = NORM_W'(ww + xx + yy + zz);
    kd = FRAC_BITS + 1;
    ko = FRAC_BITS + 2;
    m = '0;
    if (nrm == 0) begin
      m.zero_norm = 1'b1;
      return m;
    end
    m.m00 = norm_entry(ww + xx - yy - zz, nrm, kd);
    m.m01 = norm_entry(x * y - z * w, nrm, ko);
    m.m02 = norm_entry(x * z + y * w, nrm, ko);
    m.m10 = norm_entry(x * y + z * w, nrm, ko);
    m.m11 = norm_entry(ww - xx + yy - zz, nrm, kd);
    m.m12 = norm_entry(y * z - x * w, nrm, ko);
    m.m20 = norm_entry(x * z - y * w, nrm, ko);
    m.m21 = norm_entry(y * z + x * w, nrm, ko);
    m.m22 = norm_entry(ww - xx - yy + zz, nrm, kd);
    return m;
  endfunction

  task automatic check_field(string name, logic [WORD_BITS-1:0] exp_v,
                             logic [WORD_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name,
             $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Record requests and compare results at each rising edge.
  always @(posedge clk) begin
    mat_res_t e;
    if (rst_n && start && !busy) expected_mats.push_back(rotation_of(in_req));
    if (rst_n && out_valid) begin
      if (expected_mats.size() == 0) begin
        $error("result strobe with no request outstanding");
        fail_count++;
      end else begin
        e = expected_mats.pop_front();
        check_field("m00", e.m00, out_res.m00);
        check_field("m01", e.m01, out_res.m01);
        check_field("m02", e.m02, out_res.m02);
        check_field("m10", e.m10, out_res.m10);
        check_field("m11", e.m11, out_res.m11);
        check_field("m12", e.m12, out_res.m12);
        check_field("m20", e.m20, out_res.m20);
        check_field("m21", e.m21, out_res.m21);
        check_field("m22", e.m22, out_res.m22);
        check_field("zero_norm", 16'(e.zero_norm), 16'(out_res.zero_norm));
      end
    end
    pending = expected_mats.size();
  end

endmodule

// ===== bench/quaternion_to_rotation_matrix_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix testbench
// Sends directed and random quaternions with random gaps; the checker
// predicts and compares every matrix, and this top gives the verdict.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit_tb;
  import qrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  quat_req_t in_req = '0;
  logic      out_valid;
  mat_res_t  out_res;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quaternion_to_rotation_matrix_unit dut (.*);

  quaternion_to_rotation_matrix_unit_checker checker_i (.*);

  // Watchdog: cycles without a request or a result accepted.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
      1: return word_t'($urandom_range(0, 8) - 4);
      2: return word_t'(16'(int'($urandom_range(0, 32768)) - 16384));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Send one request, with a random gap first.
  task automatic send_quat(word_t w, word_t x, word_t y, word_t z);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
          ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= '{quat_w: w, quat_x: x, quat_y: y, quat_z: z};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    word_t ext[4];
    int    waited;
    ext = '{16'sh7fff, -16'sh8000, 16'sh4000, 16'sh0001};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero quaternion, identity, axis turns, extremes, tiny norms.
    send_quat(0, 0, 0, 0);
    send_quat(16'sh4000, 0, 0, 0);
    send_quat(0, 16'sh4000, 0, 0);
    send_quat(0, 0, 16'sh4000, 0);
    send_quat(0, 0, 0, 16'sh4000);
    send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 0, -1);
    send_quat(1, 1, 1, 1);
    send_quat(1, -1, 1, -1);
    send_quat(16'sh2d41, 16'sh2d41, 0, 0);
    send_quat(16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000);
    send_quat(-16'sh8000, 0, 0, 1);
    send_quat(0, 16'sh7fff, 16'sh7fff, 0);
    for (int i = 0; i < 4; i++)
      send_quat(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]);

    // Random part.
    for (int i = 0; i < 500; i++)
      send_quat(rand_word(), rand_word(), rand_word(), rand_word());
    start <= 1'b0;

    // Drain, then let the pipeline settle.
    waited = 0;
    while (pending != 0 && waited < 10 * LATENCY + 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
